### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define CAU_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// implication within the same edge
`define CAU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

### src/cau_pkg.sv
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DZ = 2'd1;
  localparam logic [1:0] ST_OV = 2'd2;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cls_item_t;

endpackage

### src/cau_in_if.sv
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] a_real;
  logic signed [31:0] a_imag;
  logic signed [31:0] b_real;
  logic signed [31:0] b_imag;

  modport source(output valid, func, a_real, a_imag, b_real, b_imag, input ready);
  modport sink(input valid, func, a_real, a_imag, b_real, b_imag, output ready);
endinterface

### src/cau_out_if.sv
interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_real;
  logic signed [31:0] res_imag;
  logic [1:0]         status;

  modport source(output valid, res_real, res_imag, status, input ready);
  modport sink(input valid, res_real, res_imag, status, output ready);
endinterface

### src/cau_front.sv
module cau_front (
  input  logic               clk,
  input  logic               rst,
  cau_in_if.sink             in_ch,
  output logic               fv,
  input  logic               fready,
  output cau_pkg::cls_item_t fitem
);
  import cau_pkg::*;

  logic take;

  assign in_ch.ready = !fv || fready;
  assign take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ch.ready) begin
      fv <= in_ch.valid;
    end
    if (take) begin
      fitem.op      <= op_t'(in_ch.func);
      fitem.a_real  <= in_ch.a_real;
      fitem.a_imag  <= in_ch.a_imag;
      fitem.b_real  <= in_ch.b_real;
      fitem.b_imag  <= in_ch.b_imag;
    end
  end
endmodule

### src/cau_queue.sv
module cau_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wv,
  output logic               wready,
  input  cau_pkg::cls_item_t witem,
  output logic               rv,
  input  logic               rready,
  output cau_pkg::cls_item_t ritem
);
  import cau_pkg::*;

  localparam int AW = $clog2(Q_DEPTH);

  cls_item_t        mem [Q_DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             wr;
  logic             rd;

  assign wready = count != (AW+1)'(Q_DEPTH);
  assign rv     = count != '0;
  assign ritem  = mem[rptr];
  assign wr     = wv && wready;
  assign rd     = rv && rready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
    if (wr) mem[wptr] <= witem;
  end
endmodule

### src/cau_back.sv
module cau_back #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               qv,
  output logic               qready,
  input  cau_pkg::cls_item_t qitem,
  cau_out_if.source          out_ch
);
  import cau_pkg::*;

  localparam int DIV_STAGES = 33;
  localparam int NW = 64 + FRAC_BITS;

  typedef struct packed {
    op_t         op;
    logic        dz;
    logic        big_r;
    logic        big_i;
    logic        neg_r;
    logic        neg_i;
    logic [63:0] den;
    logic [63:0] rem_r;
    logic [63:0] rem_i;
    logic [32:0] low_r;
    logic [32:0] low_i;
    logic [32:0] q_r;
    logic [32:0] q_i;
    logic [31:0] res_r;
    logic [31:0] res_i;
    logic        ov;
  } dstage_t;

  function automatic logic [32:0] sat33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  function automatic logic [32:0] sat_mag(input logic neg, input logic big,
                                          input logic [32:0] q);
    logic [32:0] r;
    if (!neg) begin
      if (big || q > 33'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, q[31:0]};
    end else begin
      if (big || q > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - q[31:0]};
    end
    return r;
  endfunction

  logic adv;
  logic v1, v2, v3, vo;
  logic [DIV_STAGES-1:0] dv;

  op_t                s1_op;
  logic signed [63:0] pac, pbd, pbc, pad, pcc, pdd;
  logic [31:0]        s1_res_r, s1_res_i;
  logic               s1_ov;

  op_t                s2_op;
  logic signed [64:0] s2_r, s2_i;
  logic [63:0]        s2_den;
  logic [31:0]        s2_res_r, s2_res_i;
  logic               s2_ov;

  logic signed [32:0] as_r, as_i;
  logic [32:0]        sa_r, sa_i;

  logic signed [64:0] sh_r, sh_i;
  logic [32:0]        ms_r, ms_i;
  logic [63:0]        mag_r, mag_i;
  logic [NW-1:0]      n_r, n_i;
  dstage_t            s3;

  dstage_t            ds [DIV_STAGES+1];
  dstage_t            dn [DIV_STAGES];

  logic [32:0]        fr, fi;

  assign adv    = !vo || out_ch.ready;
  assign qready = adv;

  always_comb begin
    if (qitem.op == OP_SUB) begin
      as_r = 33'(qitem.a_real) - 33'(qitem.b_real);
      as_i = 33'(qitem.a_imag) - 33'(qitem.b_imag);
    end else begin
      as_r = 33'(qitem.a_real) + 33'(qitem.b_real);
      as_i = 33'(qitem.a_imag) + 33'(qitem.b_imag);
    end
    sa_r = sat33(as_r);
    sa_i = sat33(as_i);
  end

  always_comb begin
    sh_r  = s2_r >>> FRAC_BITS;
    sh_i  = s2_i >>> FRAC_BITS;
    ms_r  = (sh_r[64:31] == '0 || sh_r[64:31] == '1) ? {1'b0, sh_r[31:0]} :
            {1'b1, sh_r[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    ms_i  = (sh_i[64:31] == '0 || sh_i[64:31] == '1) ? {1'b0, sh_i[31:0]} :
            {1'b1, sh_i[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    mag_r = s2_r[64] ? 64'(-s2_r) : s2_r[63:0];
    mag_i = s2_i[64] ? 64'(-s2_i) : s2_i[63:0];
    n_r   = NW'(mag_r) << FRAC_BITS;
    n_i   = NW'(mag_i) << FRAC_BITS;
    s3.op    = s2_op;
    s3.den   = s2_den;
    s3.dz    = s2_den == '0;
    s3.neg_r = s2_r[64];
    s3.neg_i = s2_i[64];
    s3.rem_r = 64'(n_r >> DIV_STAGES);
    s3.rem_i = 64'(n_i >> DIV_STAGES);
    s3.big_r = 64'(n_r >> DIV_STAGES) >= s2_den;
    s3.big_i = 64'(n_i >> DIV_STAGES) >= s2_den;
    s3.low_r = n_r[32:0];
    s3.low_i = n_i[32:0];
    s3.q_r   = '0;
    s3.q_i   = '0;
    if (s2_op == OP_MUL) begin
      s3.res_r = ms_r[31:0];
      s3.res_i = ms_i[31:0];
      s3.ov    = ms_r[32] | ms_i[32];
    end else begin
      s3.res_r = s2_res_r;
      s3.res_i = s2_res_i;
      s3.ov    = s2_ov;
    end
  end

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      logic [64:0] tr, ti;
      tr = {ds[k].rem_r, ds[k].low_r[32]};
      ti = {ds[k].rem_i, ds[k].low_i[32]};
      dn[k]       = ds[k];
      dn[k].low_r = {ds[k].low_r[31:0], 1'b0};
      dn[k].low_i = {ds[k].low_i[31:0], 1'b0};
      if (tr >= {1'b0, ds[k].den}) begin
        dn[k].rem_r = 64'(tr - {1'b0, ds[k].den});
        dn[k].q_r   = {ds[k].q_r[31:0], 1'b1};
      end else begin
        dn[k].rem_r = tr[63:0];
        dn[k].q_r   = {ds[k].q_r[31:0], 1'b0};
      end
      if (ti >= {1'b0, ds[k].den}) begin
        dn[k].rem_i = 64'(ti - {1'b0, ds[k].den});
        dn[k].q_i   = {ds[k].q_i[31:0], 1'b1};
      end else begin
        dn[k].rem_i = ti[63:0];
        dn[k].q_i   = {ds[k].q_i[31:0], 1'b0};
      end
    end
  end

  assign fr = sat_mag(ds[DIV_STAGES].neg_r, ds[DIV_STAGES].big_r, ds[DIV_STAGES].q_r);
  assign fi = sat_mag(ds[DIV_STAGES].neg_i, ds[DIV_STAGES].big_i, ds[DIV_STAGES].q_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dv <= '0;
      vo <= 1'b0;
    end else if (adv) begin
      v1 <= qv;
      v2 <= v1;
      v3 <= v2;
      dv <= {dv[DIV_STAGES-2:0], v3};
      vo <= dv[DIV_STAGES-1];
    end
    if (adv) begin
      s1_op    <= qitem.op;
      pac      <= 64'(qitem.a_real * qitem.b_real);
      pbd      <= 64'(qitem.a_imag * qitem.b_imag);
      pbc      <= 64'(qitem.a_imag * qitem.b_real);
      pad      <= 64'(qitem.a_real * qitem.b_imag);
      pcc      <= 64'(qitem.b_real * qitem.b_real);
      pdd      <= 64'(qitem.b_imag * qitem.b_imag);
      s1_res_r <= sa_r[31:0];
      s1_res_i <= sa_i[31:0];
      s1_ov    <= sa_r[32] | sa_i[32];

      s2_op    <= s1_op;
      s2_r     <= (s1_op == OP_MUL) ? 65'(pac) - 65'(pbd) : 65'(pac) + 65'(pbd);
      s2_i     <= (s1_op == OP_MUL) ? 65'(pbc) + 65'(pad) : 65'(pbc) - 65'(pad);
      s2_den   <= pcc[63:0] + pdd[63:0];
      s2_res_r <= s1_res_r;
      s2_res_i <= s1_res_i;
      s2_ov    <= s1_ov;

      ds[0] <= s3;
      for (int k = 0; k < DIV_STAGES; k++) begin
        ds[k+1] <= dn[k];
      end

      if (ds[DIV_STAGES].op == OP_DIV) begin
        if (ds[DIV_STAGES].dz) begin
          out_ch.res_real <= '0;
          out_ch.res_imag <= '0;
          out_ch.status   <= ST_DZ;
        end else begin
          out_ch.res_real <= fr[31:0];
          out_ch.res_imag <= fi[31:0];
          out_ch.status   <= (fr[32] | fi[32]) ? ST_OV : ST_OK;
        end
      end else begin
        out_ch.res_real <= ds[DIV_STAGES].res_r;
        out_ch.res_imag <= ds[DIV_STAGES].res_i;
        out_ch.status   <= ds[DIV_STAGES].ov ? ST_OV : ST_OK;
      end
    end
  end

  assign out_ch.valid = vo;
endmodule

### src/complex_arith_unit.sv
// Complex add, subtract, multiply and divide on signed 32-bit fixed-point parts with
// FRAC_BITS fraction bits. One item is taken every cycle while the output is not stalled;
// each result passes through the front register, which takes the item at the edge that
// accepts it, then a queue slot, three product and sum stages, 33 stages of a restoring
// divider (one quotient bit each) and the output register.
// Every operation runs through the same pipeline so results stay in order. A zero
// divisor gives a zero result with status 1; any saturated part gives status 2.
`include "assert_macros.svh"

module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  cau_in_if.sink     in_ch,
  cau_out_if.source  out_ch
);
  import cau_pkg::*;

  logic      fv, fready, qv, qready;
  cls_item_t fitem, qitem;

  cau_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .fv     (fv),
    .fready (fready),
    .fitem  (fitem)
  );

  cau_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wv     (fv),
    .wready (fready),
    .witem  (fitem),
    .rv     (qv),
    .rready (qready),
    .ritem  (qitem)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .qv     (qv),
    .qready (qready),
    .qitem  (qitem),
    .out_ch (out_ch)
  );

  `CAU_ASSERT(a_status_code, !out_ch.valid || out_ch.status != 2'd3)
  `CAU_ASSERT_IMP(a_dz_zero, out_ch.valid && out_ch.status == ST_DZ, out_ch.res_real == '0 && out_ch.res_imag == '0)
  `CAU_ASSERT_IMP(a_queue_flow, qv && qready, $past(fv) || $past(qv))
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cau_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         st;
  } cplx_res_t;

  logic clk;
  logic rst;

  cau_in_if  in_ch();
  cau_out_if out_ch();

  complex_arith_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  cplx_res_t result_q[$];
  bit        failed;
  int        cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      hold_off;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic cplx_res_t complex_result(op_t op, logic signed [31:0] ar,
                                               logic signed [31:0] ai,
                                               logic signed [31:0] br,
                                               logic signed [31:0] bi);
    logic signed [127:0] a, b, c, d, pr, pi, den;
    bit ov;
    cplx_res_t r;
    a = ar;
    b = ai;
    c = br;
    d = bi;
    ov = 1'b0;
    r.st = ST_OK;
    r.re = '0;
    r.im = '0;
    case (op)
      OP_ADD: begin
        pr = a + c;
        pi = b + d;
      end
      OP_SUB: begin
        pr = a - c;
        pi = b - d;
      end
      OP_MUL: begin
        pr = (a * c - b * d) >>> FRAC;
        pi = (b * c + a * d) >>> FRAC;
      end
      default: begin
        den = c * c + d * d;
        if (den != 0) begin
          pr = ((a * c + b * d) <<< FRAC) / den;
          pi = ((b * c - a * d) <<< FRAC) / den;
        end
      end
    endcase
    if (op == OP_DIV && c == 0 && d == 0) begin
      r.st = ST_DZ;
    end else begin
      r.re = clamp32(pr, ov);
      r.im = clamp32(pi, ov);
      if (ov) r.st = ST_OV;
    end
    return r;
  endfunction

  task automatic send_item(op_t op, logic signed [31:0] ar, logic signed [31:0] ai,
                           logic signed [31:0] br, logic signed [31:0] bi);
    in_ch.valid  <= 1'b1;
    in_ch.func   <= op;
    in_ch.a_real <= ar;
    in_ch.a_imag <= ai;
    in_ch.b_real <= br;
    in_ch.b_imag <= bi;
    do @(posedge clk); while (!in_ch.ready);
    result_q.push_back(complex_result(op, ar, ai, br, bi));
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
      3: begin
        case ($urandom_range(5))
          0: return 32'h80000000;
          1: return 32'h7FFFFFFF;
          2: return 32'h00000000;
          3: return 32'hFFFFFFFF;
          4: return 32'h00010000;
          default: return 32'hFFFF0000;
        endcase
      end
      default: return $signed($urandom_range(0, 32'hFFFFFF)) - 32'sh7FFFFF;
    endcase
  endfunction

  task automatic send_random();
    op_t op;
    logic signed [31:0] c, d;
    op = op_t'($urandom_range(3));
    c = rand_part();
    d = rand_part();
    if ($urandom_range(19) == 0) begin
      c = '0;
      d = '0;
    end
    send_item(op, rand_part(), rand_part(), c, d);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(OP_ADD, 32'sd65536, 32'sd131072, -32'sd65536, 32'sd5);
    send_item(OP_SUB, 32'sd100, -32'sd7, 32'sd3, 32'sd9);
    send_item(OP_MUL, 32'sd131072, 32'sd65536, 32'sd65536, -32'sd65536);
    send_item(OP_DIV, 32'sd65536, 32'sd0, 32'sd131072, 32'sd0);
    send_item(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'sd1, -32'sd1);
    send_item(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'sd1, -32'sd1);
    send_item(OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(OP_SUB, 32'h7FFFFFFF, 32'h00000000, 32'h80000000, 32'h80000000);
    send_item(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(OP_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0);
    send_item(OP_MUL, -32'sd3, 32'sd1, 32'sd5, -32'sd2);
    send_item(OP_DIV, 32'sd5, 32'sd7, 32'sd0, 32'sd0);
    send_item(OP_DIV, 32'h80000000, 32'h7FFFFFFF, 32'sd0, 32'sd0);
    send_item(OP_DIV, 32'h7FFFFFFF, 32'h80000000, 32'sd1, 32'sd0);
    send_item(OP_DIV, 32'h80000000, 32'h80000000, 32'sd0, -32'sd1);
    send_item(OP_DIV, 32'sd1, 32'sd0, 32'h80000000, 32'h80000000);
    send_item(OP_DIV, -32'sd65536, 32'sd1, 32'sd196608, 32'sd0);
    send_item(OP_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    send_item(OP_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_SUB, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
  endtask

  task automatic test_random(int sidle, int rstall, int n);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) send_random();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (90) send_random();
  endtask

  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected item re=%0d im=%0d st=%0d", $time,
                 out_ch.res_real, out_ch.res_imag, out_ch.status);
        failed = 1'b1;
      end else begin
        e = result_q.pop_front();
        if (out_ch.res_real !== e.re || out_ch.res_imag !== e.im ||
            out_ch.status !== e.st) begin
          $display("%0t: mismatch exp re=%0d im=%0d st=%0d got re=%0d im=%0d st=%0d",
                   $time, e.re, e.im, e.st, out_ch.res_real, out_ch.res_imag,
                   out_ch.status);
          failed = 1'b1;
        end
      end
    end
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[complex_arith_unit] ERROR");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    failed = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = OP_ADD;
    in_ch.a_real = '0;
    in_ch.a_imag = '0;
    in_ch.b_real = '0;
    in_ch.b_imag = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 300);
    test_random(46, 0, 300);
    test_random(0, 46, 300);
    test_random(15, 15, 300);
    test_backpressure();
    test_random(0, 0, 160);
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("[complex_arith_unit] OK");
    end else begin
      $display("[complex_arith_unit] ERROR");
    end
    $finish;
  end

endmodule
